// ===== hdl/ffud_pkg.sv =====
// Shared types, constants and helper functions of the form field decoder.
package ffud_pkg;

  localparam int NAME_MAX  = 16;
  localparam int OUT_MAX   = 4096;
  localparam int KEYPOS_W  = 5;
  localparam int NLEN_W    = 5;
  localparam int SIZE_W    = 13;
  localparam int LEN_W     = 12;
  localparam int MAX_RES   = 4;
  localparam int RIDX_W    = 2;
  localparam int RCNT_W    = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_FOUND  = 2'd1,
    KIND_ABSENT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_NAME_LOW  = 2'd0,
    REG_NAME_HIGH = 2'd1,
    REG_NAME_LEN  = 2'd2,
    REG_OUT_SIZE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_KEY   = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'b00,
    ESC_PCT   = 2'b01,
    ESC_DIGIT = 2'b10
  } esc_t;

  typedef struct packed {
    logic [63:0]       name_low;
    logic [63:0]       name_high;
    logic [NLEN_W-1:0] name_length;
    logic [SIZE_W-1:0] out_size;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [KEYPOS_W-1:0] key_position;
    logic                key_mismatch;
    esc_t                escape_held;
    logic [7:0]          held_hex_char;
    logic [LEN_W-1:0]    output_count;
    logic                field_found;
  } state_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       has_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       decoded_byte;
    logic [LEN_W-1:0] decoded_length;
    logic             last_result;
  } result_t;

  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [RCNT_W-1:0]     count;
  } bundle_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_KEY,
    key_position:  '0,
    key_mismatch:  1'b0,
    escape_held:   ESC_NONE,
    held_hex_char: '0,
    output_count:  '0,
    field_found:   1'b0
  };

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = (c <= 8'h39) ? (c - 8'h30) : ((c | 8'h20) - 8'h57);
    return t[3:0];
  endfunction

endpackage

// ===== hdl/ffud_in_if.sv =====
// Input channel carrying one body byte per transfer.
interface ffud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, body_byte, has_byte, last_byte, input ready);
  modport sink   (input valid, body_byte, has_byte, last_byte, output ready);
endinterface

// ===== hdl/ffud_out_if.sv =====
// Result channel carrying decoded bytes and the end-of-body status.
interface ffud_out_if import ffud_pkg::*;;
  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [7:0]       decoded_byte;
  logic [LEN_W-1:0] decoded_length;
  logic             last_result;

  modport source (output valid, kind, decoded_byte, decoded_length, last_result,
                  input ready);
  modport sink   (input valid, kind, decoded_byte, decoded_length, last_result,
                  output ready);
endinterface

// ===== hdl/form_field_url_decoder.sv =====
// The first result of an item is offered in the cycle after its transfer.
// One body byte per cycle while each byte gives at most one result and the
// receiver is ready; a byte that gives more (up to four) holds the input until
// the result queue, which hands out one result per ready cycle, sends its last.
// Reset (rst, synchronous, active high) returns the parse state to its reset value
// and clears the result queue and all configuration registers to zero.
module form_field_url_decoder import ffud_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ffud_in_if.sink     body,
  ffud_out_if.source  result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  cfg_t    cfg;

  // Parse state of the current body: phase, key match progress, pending escape
  // and the number of decoded bytes given so far.
  state_t  st;
  state_t  st_next;

  item_t   item;
  bundle_t bundle;
  logic    can_load;
  logic    accept;

  assign item   = '{body_byte: body.body_byte, has_byte: body.has_byte,
                    last_byte: body.last_byte};

  // A new byte is taken whenever the result queue is empty or its final result
  // leaves in this same cycle, so the queue doubles as the output register.
  assign body.ready = can_load;
  assign accept     = body.valid && body.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NAME_LOW:  cfg.name_low    <= cfg_data;
        REG_NAME_HIGH: cfg.name_high   <= cfg_data;
        REG_NAME_LEN:  cfg.name_length <= cfg_data[NLEN_W-1:0];
        REG_OUT_SIZE:  cfg.out_size    <= cfg_data[SIZE_W-1:0];
      endcase
    end
  end

  // The state advances once per transfer; the last byte of a body returns it
  // to the reset value so the next transfer starts a new body.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  ffud_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .bundle  (bundle)
  );

  ffud_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .bundle   (bundle),
    .can_load (can_load),
    .result   (result)
  );

endmodule

// ===== hdl/ffud_step.sv =====
// Per-byte parse and decode logic: next state and the results of one item.
module ffud_step import ffud_pkg::*; (
  input  state_t  st,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  st_next,
  output bundle_t bundle
);

  logic [7:0]        cand [MAX_RES];
  logic [RCNT_W-1:0] cn;
  logic              plain_go;
  logic [127:0]      name_all;
  logic [7:0]        name_b;
  logic [SIZE_W-1:0] lim;
  logic [SIZE_W-1:0] oc1;
  logic [SIZE_W-1:0] room;
  logic [RCNT_W-1:0] acc;
  logic [LEN_W-1:0]  oc_new;
  logic [7:0]        b;
  state_t            st_upd;

  assign name_all = {cfg.name_high, cfg.name_low};
  assign name_b   = name_all[{st.key_position[3:0], 3'b000} +: 8];
  assign b        = item.body_byte;

  always_comb begin
    st_upd   = st;
    cn       = '0;
    plain_go = 1'b0;
    for (int k = 0; k < MAX_RES; k++) begin
      cand[k] = '0;
    end

    if (item.has_byte) begin
      unique case (st.phase)
        PH_KEY: begin
          if (b == CH_AMP) begin
            st_upd.key_position = '0;
            st_upd.key_mismatch = 1'b0;
          end else if (b == CH_EQ) begin
            if (!st.key_mismatch && st.key_position == cfg.name_length &&
                cfg.name_length <= NLEN_W'(NAME_MAX)) begin
              st_upd.phase       = PH_VALUE;
              st_upd.field_found = 1'b1;
            end else begin
              st_upd.phase = PH_SKIP;
            end
            st_upd.key_position = '0;
            st_upd.key_mismatch = 1'b0;
          end else begin
            if (st.key_position >= cfg.name_length ||
                st.key_position >= KEYPOS_W'(NAME_MAX) || name_b != b) begin
              st_upd.key_mismatch = 1'b1;
            end
            if (st.key_position != '1) begin
              st_upd.key_position = st.key_position + 1'b1;
            end
          end
        end
        PH_SKIP: begin
          if (b == CH_AMP) begin
            st_upd.phase = PH_KEY;
          end
        end
        PH_VALUE: begin
          unique case (st.escape_held)
            ESC_PCT: begin
              if (is_hex(b)) begin
                st_upd.held_hex_char = b;
                st_upd.escape_held   = ESC_DIGIT;
              end else begin
                st_upd.escape_held = ESC_NONE;
                cand[cn[RIDX_W-1:0]] = CH_PCT;
                cn       = cn + 1'b1;
                plain_go = 1'b1;
              end
            end
            ESC_DIGIT: begin
              st_upd.escape_held = ESC_NONE;
              if (is_hex(b)) begin
                cand[cn[RIDX_W-1:0]] = {hex_val(st.held_hex_char), hex_val(b)};
                cn = cn + 1'b1;
              end else begin
                cand[cn[RIDX_W-1:0]] = CH_PCT;
                cn = cn + 1'b1;
                cand[cn[RIDX_W-1:0]] = st.held_hex_char;
                cn       = cn + 1'b1;
                plain_go = 1'b1;
              end
            end
            default: plain_go = 1'b1;
          endcase
          // Ordinary value byte once any pending escape has been resolved.
          if (plain_go) begin
            if (b == CH_AMP) begin
              st_upd.phase = PH_DONE;
            end else if (b == CH_PLUS) begin
              cand[cn[RIDX_W-1:0]] = CH_SPACE;
              cn = cn + 1'b1;
            end else if (b == CH_PCT) begin
              st_upd.escape_held = ESC_PCT;
            end else begin
              cand[cn[RIDX_W-1:0]] = b;
              cn = cn + 1'b1;
            end
          end
        end
        PH_DONE: ;
      endcase
    end

    // An escape still open at the end of the body goes out verbatim.
    if (item.last_byte && st_upd.phase == PH_VALUE) begin
      if (st_upd.escape_held != ESC_NONE) begin
        cand[cn[RIDX_W-1:0]] = CH_PCT;
        cn = cn + 1'b1;
      end
      if (st_upd.escape_held == ESC_DIGIT) begin
        cand[cn[RIDX_W-1:0]] = st_upd.held_hex_char;
        cn = cn + 1'b1;
      end
    end
  end

  // Bytes past the buffer limit are dropped; the kept ones are a prefix.
  always_comb begin
    lim    = (cfg.out_size > SIZE_W'(OUT_MAX)) ? SIZE_W'(OUT_MAX) : cfg.out_size;
    oc1    = {1'b0, st.output_count} + 1'b1;
    room   = (lim > oc1) ? (lim - oc1) : '0;
    acc    = (room < SIZE_W'(cn)) ? room[RCNT_W-1:0] : cn;
    oc_new = st.output_count + LEN_W'(acc);
  end

  always_comb begin
    state_t s;
    s = st_upd;
    s.output_count = oc_new;
    for (int k = 0; k < MAX_RES; k++) begin
      bundle.res[k] = '{kind: KIND_BYTE, decoded_byte: cand[k],
                        decoded_length: '0, last_result: 1'b0};
      if (RCNT_W'(k) == acc && item.last_byte) begin
        if (st_upd.field_found && cfg.out_size != '0) begin
          bundle.res[k] = '{kind: KIND_FOUND, decoded_byte: '0,
                            decoded_length: oc_new, last_result: 1'b1};
        end else begin
          bundle.res[k] = '{kind: KIND_ABSENT, decoded_byte: '0,
                            decoded_length: '0, last_result: 1'b1};
        end
      end
    end
    bundle.count = acc + RCNT_W'(item.last_byte);
    st_next      = item.last_byte ? STATE_RESET : s;
  end

endmodule

// ===== hdl/ffud_result_queue.sv =====
// Holds the results of one item and hands them out one per transfer.
module ffud_result_queue import ffud_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  bundle_t    bundle,
  output logic       can_load,
  ffud_out_if.source result
);

  result_t           res [MAX_RES];
  logic [RCNT_W-1:0] count;
  logic [RCNT_W-1:0] ptr;
  logic              take;
  logic              final_take;

  assign result.valid = (ptr != count);
  assign take         = result.valid && result.ready;
  assign final_take   = take && (ptr + 1'b1 == count);
  assign can_load     = !result.valid || final_take;

  assign result.kind           = res[ptr[RIDX_W-1:0]].kind;
  assign result.decoded_byte   = res[ptr[RIDX_W-1:0]].decoded_byte;
  assign result.decoded_length = res[ptr[RIDX_W-1:0]].decoded_length;
  assign result.last_result    = res[ptr[RIDX_W-1:0]].last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
    end else if (load) begin
      count <= bundle.count;
      ptr   <= '0;
    end else if (take) begin
      ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < MAX_RES; k++) begin
        res[k] <= bundle.res[k];
      end
    end
  end

endmodule

// ===== hdl/ffud_checker.sv =====
// Port-level checks of the form field decoder, bound to the top level.
module ffud_checker import ffud_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last,
  input logic             out_valid,
  input logic             out_ready,
  input kind_t            out_kind,
  input logic [7:0]       out_byte,
  input logic [LEN_W-1:0] out_length,
  input logic             out_last
);

  logic [1:0]       pending;
  logic [LEN_W-1:0] byte_count;
  logic             in_end;
  logic             out_status;
  logic             out_data;

  assign in_end     = in_valid && in_ready && in_last;
  assign out_status = out_valid && out_ready && out_last;
  assign out_data   = out_valid && out_ready && out_kind == KIND_BYTE;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      byte_count <= '0;
    end else begin
      pending    <= pending + 2'(in_end) - 2'(out_status);
      byte_count <= out_status ? '0 : byte_count + LEN_W'(out_data);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_byte) && $stable(out_length) && $stable(out_last))
    else $error("result changed while stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  a_status_owed: assert property (@(posedge clk) disable iff (rst)
    (out_status |-> pending != 2'd0) and (pending <= 2'd1))
    else $error("status result does not match ended bodies");

  a_length: assert property (@(posedge clk) disable iff (rst)
    out_status && out_kind == KIND_FOUND |-> out_length == byte_count)
    else $error("decoded length differs from bytes transferred");

endmodule

bind form_field_url_decoder ffud_checker u_ffud_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (body.valid),
  .in_ready   (body.ready),
  .in_last    (body.last_byte),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_kind   (result.kind),
  .out_byte   (result.decoded_byte),
  .out_length (result.decoded_length),
  .out_last   (result.last_result)
);

// ===== test/tb_form_field_url_decoder.sv =====
// Testbench of the form field decoder: directed and random form bodies checked against a predictor.
module tb_form_field_url_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ffud_pkg::*;

  // The run is cut off here if the block stops moving. A correct run needs far
  // fewer cycles, even with four results per item and the longest stalls.
  localparam int CYCLE_LIMIT = 300000;
  // Number of random items (not counting ignored idle items) to send.
  localparam int RANDOM_ITEMS = 180;
  // Extra cycles granted after the last result, since an item that gives no
  // result may still be in flight when the expectation store runs dry.
  localparam int QUIET_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  ffud_in_if  body_ch ();
  ffud_out_if result_ch ();

  form_field_url_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .body      (body_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the registers and of the parse state,
  // and for every accepted body byte it appends the results the block owes.
  // ---------------------------------------------------------------------------
  cfg_t             shadow_cfg;
  phase_t           parse_phase;
  logic [4:0]       key_pos;
  logic             key_bad;
  esc_t             escape;
  logic [7:0]       held_digit;
  logic [LEN_W-1:0] decoded_count;
  logic             match_seen;

  result_t decoded_results[$];
  int      errors = 0;

  function automatic logic [7:0] name_at(int p);
    return (p < 8) ? shadow_cfg.name_low[p*8 +: 8] : shadow_cfg.name_high[(p-8)*8 +: 8];
  endfunction

  // Returns {is_digit, value} for one character of a percent escape.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (low >= "a" && low <= "f") return {1'b1, c[3:0] + 4'd9};
    return 5'b0;
  endfunction

  function automatic void owe_result(kind_t k, logic [7:0] b, logic [LEN_W-1:0] n, logic l);
    decoded_results.push_back('{kind: k, decoded_byte: b, decoded_length: n, last_result: l});
  endfunction

  // One decoded byte; it is dropped once the buffer holds out_size (capped at OUT_MAX) minus one.
  function automatic void put_decoded(logic [7:0] b);
    int limit;
    limit = (shadow_cfg.out_size < OUT_MAX) ? int'(shadow_cfg.out_size) : OUT_MAX;
    if (int'(decoded_count) + 1 < limit) begin
      owe_result(KIND_BYTE, b, '0, 1'b0);
      decoded_count++;
    end
  endfunction

  function automatic void clear_parse();
    parse_phase   = PH_KEY;
    key_pos       = '0;
    key_bad       = 1'b0;
    escape        = ESC_NONE;
    held_digit    = '0;
    decoded_count = '0;
    match_seen    = 1'b0;
  endfunction

  function automatic void value_unescaped(logic [7:0] b);
    if (b == CH_AMP) parse_phase = PH_DONE;
    else if (b == CH_PLUS) put_decoded(CH_SPACE);
    else if (b == CH_PCT) escape = ESC_PCT;
    else put_decoded(b);
  endfunction

  function automatic void value_char(logic [7:0] b);
    logic [4:0] lo_nib;
    logic [4:0] hi_nib;
    lo_nib = hex_digit(b);
    case (escape)
      ESC_PCT: begin
        if (lo_nib[4]) begin
          held_digit = b;
          escape     = ESC_DIGIT;
        end else begin
          escape = ESC_NONE;
          put_decoded(CH_PCT);
          value_unescaped(b);
        end
      end
      ESC_DIGIT: begin
        escape = ESC_NONE;
        if (lo_nib[4]) begin
          hi_nib = hex_digit(held_digit);
          put_decoded({hi_nib[3:0], lo_nib[3:0]});
        end else begin
          put_decoded(CH_PCT);
          put_decoded(held_digit);
          value_unescaped(b);
        end
      end
      default: value_unescaped(b);
    endcase
  endfunction

  function automatic void key_char_in(logic [7:0] b);
    if (b == CH_AMP) begin
      key_pos = '0;
      key_bad = 1'b0;
    end else if (b == CH_EQ) begin
      if (!key_bad && key_pos == shadow_cfg.name_length && shadow_cfg.name_length <= NAME_MAX)
      begin
        parse_phase = PH_VALUE;
        match_seen  = 1'b1;
      end else begin
        parse_phase = PH_SKIP;
      end
      key_pos = '0;
      key_bad = 1'b0;
    end else begin
      if (key_pos >= shadow_cfg.name_length || key_pos >= NAME_MAX || name_at(key_pos) != b)
        key_bad = 1'b1;
      if (key_pos < 5'd31) key_pos++;
    end
  endfunction

  function automatic void decode_step(item_t it);
    if (it.has_byte) begin
      case (parse_phase)
        PH_KEY:   key_char_in(it.body_byte);
        PH_SKIP:  if (it.body_byte == CH_AMP) parse_phase = PH_KEY;
        PH_VALUE: value_char(it.body_byte);
        default:  ;
      endcase
    end
    if (it.last_byte) begin
      // A percent escape cut off by the end of the body goes out verbatim.
      if (parse_phase == PH_VALUE) begin
        if (escape != ESC_NONE) put_decoded(CH_PCT);
        if (escape == ESC_DIGIT) put_decoded(held_digit);
        escape = ESC_NONE;
      end
      if (match_seen && shadow_cfg.out_size != 0)
        owe_result(KIND_FOUND, 8'h00, decoded_count, 1'b1);
      else
        owe_result(KIND_ABSENT, 8'h00, '0, 1'b1);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change at the falling edge; a transfer happens at the
  // rising edge where valid and ready are both high. The sender works in bursts
  // of random length, with random gaps in between, some of them long.
  // ---------------------------------------------------------------------------
  bit driving   = 0;
  int burst_len = 0;
  int accepted_items;

  // A typed status replaces the predicted one right at the transfer, while it
  // is still owed, since the block registers an item's results before offering them.
  task automatic send_item(logic [7:0] b, logic has, logic last, logic typed = 1'b0,
                           kind_t want_kind = KIND_BYTE, logic [LEN_W-1:0] want_len = '0);
    item_t it;
    it = '{body_byte: b, has_byte: has, last_byte: last};
    body_ch.valid     <= 1'b1;
    body_ch.body_byte <= b;
    body_ch.has_byte  <= has;
    body_ch.last_byte <= last;
    driving = 1;
    @(posedge clk);
    while (!body_ch.ready) @(posedge clk);
    decode_step(it);
    if (typed)
      decoded_results[decoded_results.size() - 1] = '{kind: want_kind,
          decoded_byte: 8'h00, decoded_length: want_len, last_result: 1'b1};
    if (has || last) accepted_items++;
    @(negedge clk);
    if (burst_len > 0) begin
      burst_len--;
    end else begin
      body_ch.valid <= 1'b0;
      driving = 0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3))
        @(negedge clk);
      burst_len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 4);
    end
  endtask

  // Stops sending and waits until every owed result has come back, plus a few
  // quiet cycles. Register writes are only made after this.
  task automatic drain_and_wait();
    if (driving) begin
      body_ch.valid <= 1'b0;
      driving = 0;
    end
    while (decoded_results.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Drives one register write; the caller lowers the write enable after the
  // last write of a group, so that it is never lowered and raised in one step.
  task automatic put_reg(cfg_reg_t r, logic [63:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    case (r)
      REG_NAME_LOW:  shadow_cfg.name_low    = d;
      REG_NAME_HIGH: shadow_cfg.name_high   = d;
      REG_NAME_LEN:  shadow_cfg.name_length = d[NLEN_W-1:0];
      default:       shadow_cfg.out_size    = d[SIZE_W-1:0];
    endcase
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. The stall pattern cycles through three modes: always
  // ready, a random stall on about a third of the cycles, and rare runs of
  // stalled cycles.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int rx_tick    = 0;

  always @(negedge clk) begin
    rx_tick++;
    case ((rx_tick / 256) % 3)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 2) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          result_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 8);
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    endcase
  end

  // Every result transfer is compared, field by field, with the oldest owed
  // result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (decoded_results.size() == 0) begin
        errors++;
        $error("result with nothing owed: kind %0d byte %02h length %0d last %0b",
               result_ch.kind, result_ch.decoded_byte, result_ch.decoded_length,
               result_ch.last_result);
      end else begin
        want = decoded_results.pop_front();
        if (result_ch.kind !== want.kind) begin
          errors++;
          $error("kind: expected %0d, got %0d", want.kind, result_ch.kind);
        end
        if (result_ch.decoded_byte !== want.decoded_byte) begin
          errors++;
          $error("decoded_byte: expected %02h, got %02h",
                 want.decoded_byte, result_ch.decoded_byte);
        end
        if (result_ch.decoded_length !== want.decoded_length) begin
          errors++;
          $error("decoded_length: expected %0d, got %0d",
                 want.decoded_length, result_ch.decoded_length);
        end
        if (result_ch.last_result !== want.last_result) begin
          errors++;
          $error("last_result: expected %0b, got %0b",
                 want.last_result, result_ch.last_result);
        end
      end
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Register rows write one register; item rows send one body
  // item. Where a status result can be read off directly, it is typed in and
  // replaces the predicted one.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic             is_reg;
    cfg_reg_t         reg_idx;
    logic [63:0]      data;
    logic [7:0]       b;
    logic             has;
    logic             last;
    logic             typed;
    kind_t            want_kind;
    logic [LEN_W-1:0] want_len;
  } plan_row_t;

  localparam int PLAN_ROWS = 33;

  plan_row_t plan [PLAN_ROWS] = '{
    // With the reset registers: an empty body, an idle item, and a key that
    // matches the empty name while the buffer size is still zero.
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h00, 1'b0, 1'b1, 1'b1, KIND_ABSENT, 12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'hA5, 1'b0, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h3D, 1'b1, 1'b1, 1'b1, KIND_ABSENT, 12'd0},
    // Name "ab" with the largest buffer.
    '{1'b1, REG_NAME_LOW,  64'h6261,             8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE, 12'd0},
    '{1'b1, REG_NAME_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE, 12'd0},
    '{1'b1, REG_NAME_LEN,  64'd2,    8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE, 12'd0},
    '{1'b1, REG_OUT_SIZE,  64'd4096, 8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE, 12'd0},
    // "ab=%4a+%G%4z": a good escape, a plus, a broken escape, and an escape
    // with one digit cut short on the last byte, which gives four results.
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h61, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h62, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h3D, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h25, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h34, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h61, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h2B, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h25, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h47, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h25, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h34, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h7A, 1'b1, 1'b1, 1'b0, KIND_BYTE,   12'd0},
    // A name longer than the key store never matches.
    '{1'b1, REG_NAME_LEN,  64'd17, 8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b1, REG_OUT_SIZE,  64'd1,  8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h61, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h62, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h3D, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h71, 1'b1, 1'b1, 1'b1, KIND_ABSENT, 12'd0},
    // Empty name with room for a single byte; the rest of the value is dropped.
    '{1'b1, REG_NAME_LEN,  64'd0,  8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b1, REG_OUT_SIZE,  64'd2,  8'h00, 1'b0, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h26, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h3D, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'hFF, 1'b1, 1'b1, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h3D, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h00, 1'b1, 1'b0, 1'b0, KIND_BYTE,   12'd0},
    '{1'b0, REG_NAME_LOW,  64'h0,  8'h80, 1'b1, 1'b1, 1'b0, KIND_BYTE,   12'd0}
  };

  // ---------------------------------------------------------------------------
  // Random bodies. Most tokens are well formed pairs, many of them carrying
  // the wanted key, with values full of plus signs and escapes, good and
  // broken. The rest are near misses, tokens with no equals sign, long keys
  // that saturate the key position, and raw noise.
  // ---------------------------------------------------------------------------
  logic [7:0] body_text[$];

  function automatic logic [7:0] key_byte_any();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_AMP || c == CH_EQ);
    return c;
  endfunction

  function automatic logic [7:0] hex_char();
    int n;
    n = $urandom_range(0, 21);
    if (n < 10) return 8'("0" + n);
    if (n < 16) return 8'("a" + n - 10);
    return 8'("A" + n - 16);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] d;
    do begin
      c = 8'($urandom_range(0, 255));
      d = hex_digit(c);
    end while (d[4]);
    return c;
  endfunction

  function automatic void add_value();
    logic [7:0] c;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_AMP || c == CH_PCT || c == CH_PLUS);
          body_text.push_back(c);
        end
        3: body_text.push_back(CH_PLUS);
        4, 5: begin
          body_text.push_back(CH_PCT);
          body_text.push_back(hex_char());
          body_text.push_back(hex_char());
        end
        6: begin
          body_text.push_back(CH_PCT);
          body_text.push_back(non_hex_char());
        end
        7: begin
          body_text.push_back(CH_PCT);
          body_text.push_back(hex_char());
          body_text.push_back(non_hex_char());
        end
        8: body_text.push_back(8'($urandom_range(0, 255)));
        default: begin
          // A bare escape start, which the next separator or the body end cuts.
          body_text.push_back(CH_PCT);
          if ($urandom_range(0, 1)) body_text.push_back(hex_char());
        end
      endcase
    end
  endfunction

  function automatic void add_wanted_key();
    for (int p = 0; p < shadow_cfg.name_length && p < NAME_MAX; p++)
      body_text.push_back(name_at(p));
  endfunction

  function automatic void add_token();
    int start;
    int spot;
    int mode;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        add_wanted_key();
        body_text.push_back(CH_EQ);
        add_value();
      end
      4: begin
        // Near miss: the key one byte too long, one byte short, or with one
        // byte changed.
        start = body_text.size();
        add_wanted_key();
        mode = $urandom_range(0, 2);
        if (body_text.size() == start || mode == 0) begin
          body_text.push_back(key_byte_any());
        end else if (mode == 1) begin
          void'(body_text.pop_back());
        end else begin
          spot = $urandom_range(start, body_text.size() - 1);
          do c = key_byte_any(); while (c == body_text[spot]);
          body_text[spot] = c;
        end
        body_text.push_back(CH_EQ);
        add_value();
      end
      5: repeat ($urandom_range(1, 6)) body_text.push_back(key_byte_any());
      6: begin
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(17, 36) : $urandom_range(0, 5))
          body_text.push_back(key_byte_any());
        body_text.push_back(CH_EQ);
        add_value();
      end
      7: repeat ($urandom_range(1, 6)) body_text.push_back(8'($urandom_range(0, 255)));
      8: ;
      default: begin
        body_text.push_back(CH_EQ);
        add_value();
      end
    endcase
  endfunction

  function automatic void build_body();
    body_text.delete();
    if ($urandom_range(0, 19) != 0) begin
      if ($urandom_range(0, 7) == 0) body_text.push_back(CH_AMP);
      for (int t = $urandom_range(1, 4); t > 0; t--) begin
        add_token();
        if (t > 1) body_text.push_back(CH_AMP);
      end
      if ($urandom_range(0, 7) == 0) body_text.push_back(CH_AMP);
    end
  endfunction

  // Sends the built body. Idle items are sprinkled in, and the end of the
  // body sometimes comes as a separate item that carries no byte.
  task automatic send_body();
    bit split_end;
    int n;
    n = body_text.size();
    split_end = (n == 0) || ($urandom_range(0, 5) == 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(body_text[k], 1'b1, !split_end && k == n - 1);
    end
    if (split_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Picks the registers of one random phase. The first phases hit the
  // extremes: all-ones and all-zeros names of full length, the largest and
  // an oversized buffer, an empty name, a name too long to match, and
  // buffers of zero and one.
  task automatic apply_settings(int phase_no);
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [NLEN_W-1:0] len;
    logic [SIZE_W-1:0] size;
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    len  = ($urandom_range(0, 4) == 0) ? NLEN_W'($urandom_range(5, 16))
                                       : NLEN_W'($urandom_range(0, 4));
    case ($urandom_range(0, 4))
      0:       size = SIZE_W'($urandom_range(2, 3));
      1, 2:    size = SIZE_W'($urandom_range(4, 20));
      3:       size = SIZE_W'($urandom_range(21, 80));
      default: size = SIZE_W'($urandom_range(0, OUT_MAX));
    endcase
    case (phase_no)
      0: begin lo = '1; hi = '1; len = NLEN_W'(NAME_MAX); size = SIZE_W'(OUT_MAX); end
      1: begin lo = '0; hi = '0; len = NLEN_W'(NAME_MAX); size = '1; end
      2: begin len = '0; size = SIZE_W'(2); end
      3: len = NLEN_W'($urandom_range(NAME_MAX + 1, 31));
      4: size = '0;
      5: size = SIZE_W'(1);
      default: ;
    endcase
    // Bytes of the name itself avoid the separators so that the wanted key
    // can be sent; bytes past the name keep their random values.
    if (phase_no >= 2) begin
      for (int p = 0; p < len && p < NAME_MAX; p++) begin
        if (p < 8) lo[p*8 +: 8] = key_byte_any();
        else hi[(p-8)*8 +: 8] = key_byte_any();
      end
    end
    drain_and_wait();
    put_reg(REG_NAME_LOW, lo);
    put_reg(REG_NAME_HIGH, hi);
    put_reg(REG_NAME_LEN, 64'(len));
    put_reg(REG_OUT_SIZE, 64'(size));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int phase_no;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_NAME_LOW;
    cfg_data          <= '0;
    body_ch.valid     <= 1'b0;
    body_ch.body_byte <= '0;
    body_ch.has_byte  <= 1'b0;
    body_ch.last_byte <= 1'b0;
    shadow_cfg = '0;
    clear_parse();

    // Reset is held at the start and is never asserted again.
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) drain_and_wait();
        put_reg(plan[i].reg_idx, plan[i].data);
        if (i == PLAN_ROWS - 1 || !plan[i+1].is_reg) cfg_we <= 1'b0;
      end else begin
        send_item(plan[i].b, plan[i].has, plan[i].last, plan[i].typed,
                  plan[i].want_kind, plan[i].want_len);
      end
    end

    accepted_items = 0;
    phase_no = 0;
    while (accepted_items < RANDOM_ITEMS) begin
      apply_settings(phase_no);
      repeat ($urandom_range(2, 5)) begin
        if (accepted_items < RANDOM_ITEMS) begin
          build_body();
          send_body();
        end
      end
      phase_no++;
    end

    // Let every owed result arrive, then a few quiet cycles in which any stray
    // result would still be caught.
    drain_and_wait();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
